// ===== src/binary_packet_deframer_macros.svh =====
// Assertion macros used by the deframer top-level RTL.
`ifndef BINARY_PACKET_DEFRAMER_MACROS_SVH
`define BINARY_PACKET_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("binary_packet_deframer: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("binary_packet_deframer: assertion failed");

`endif

// ===== src/bpd_pkg.sv =====
`default_nettype none

package bpd_pkg;

	// Sync word "$BIN" as it appears in a left-shifting byte window.
	localparam logic [31:0] SYNC_WORD = 32'h2442_494E;

	// Register reset values.
	localparam logic [15:0] MAX_TYPE_RST   = 16'd99;
	localparam logic [15:0] MAX_LENGTH_RST = 16'd304;

	// Register indexes on the configuration port.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TYPE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'd1;

	// Deframer phases.
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CHECK   = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

	// Status codes reported on end items.
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_HEADER   = 2'd1,
		ST_TRUNCATED    = 2'd2,
		ST_BAD_CHECKSUM = 2'd3
	} status_t;

	// Header limits held by the configuration registers.
	typedef struct packed {
		logic [15:0] max_type;
		logic [15:0] max_length;
	} cfg_t;

	// One result word as it travels from the classifier to the output.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] packet_type;
		logic [15:0] packet_length;
		logic        end_of_packet;
		status_t     status;
		logic [15:0] computed_sum;
		logic [15:0] received_sum;
	} result_t;

endpackage

`default_nettype wire

// ===== src/bpd_fifo.sv =====
`default_nettype none

// Small first-in first-out queue of result words with a fall-through head.
module bpd_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bpd_pkg::result_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  valid,
	output bpd_pkg::result_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bpd_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage is written without reset; only the pointers carry control state.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the last entry, so the depth need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/bpd_front.sv =====
`default_nettype none

// Byte classifier: tracks the framing phase and builds at most one result per byte.
module bpd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	input  wire bpd_pkg::cfg_t cfg,
	output logic               res_valid,
	output bpd_pkg::result_t   res
);

	bpd_pkg::phase_t phase_q, phase_d;
	logic [31:0] win_q, win_d;
	logic [1:0]  fc_q, fc_d;
	logic [15:0] type_q, type_d;
	logic [15:0] length_q, length_d;
	logic [15:0] count_q, count_d;
	logic [15:0] sum_q, sum_d;
	logic        seen_q, seen_d;
	logic [7:0]  cs_low_q, cs_low_d;
	logic [15:0] recv_q, recv_d;

	// Framing state advances only when a word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bpd_pkg::PH_HUNT;
			win_q    <= '0;
			fc_q     <= '0;
			type_q   <= '0;
			length_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			seen_q   <= 1'b0;
			cs_low_q <= '0;
			recv_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			win_q    <= win_d;
			fc_q     <= fc_d;
			type_q   <= type_d;
			length_q <= length_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			seen_q   <= seen_d;
			cs_low_q <= cs_low_d;
			recv_q   <= recv_d;
		end
	end

	// Next state and the result word for the byte on the input.
	always_comb begin
		logic [31:0] win_shift;
		logic [15:0] sum_next;
		logic [15:0] count_next;
		logic        seen_next;

		win_shift  = {win_q[23:0], in_byte};
		sum_next   = sum_q + {8'h00, in_byte};
		count_next = count_q + 16'd1;
		seen_next  = seen_q | (win_shift == bpd_pkg::SYNC_WORD);

		phase_d  = phase_q;
		win_d    = win_q;
		fc_d     = fc_q;
		type_d   = type_q;
		length_d = length_q;
		count_d  = count_q;
		sum_d    = sum_q;
		seen_d   = seen_q;
		cs_low_d = cs_low_q;
		recv_d   = recv_q;

		res_valid         = 1'b0;
		res.data_byte     = '0;
		res.byte_index    = '0;
		res.end_of_packet = 1'b0;
		res.status        = bpd_pkg::ST_OK;
		res.computed_sum  = '0;
		res.received_sum  = '0;

		unique case (phase_q)
			bpd_pkg::PH_HUNT: begin
				win_d = win_shift;
				if (win_shift == bpd_pkg::SYNC_WORD) begin
					phase_d = bpd_pkg::PH_HEADER;
					fc_d    = '0;
				end
			end

			bpd_pkg::PH_HEADER: begin
				unique case (fc_q)
					2'd0: type_d   = {8'h00, in_byte};
					2'd1: type_d   = {in_byte, type_q[7:0]};
					2'd2: length_d = {8'h00, in_byte};
					2'd3: length_d = {in_byte, length_q[7:0]};
				endcase
				if (fc_q != 2'd3) begin
					fc_d = fc_q + 2'd1;
				end else begin
					// Header complete: check the limits and start a fresh payload.
					fc_d    = '0;
					count_d = '0;
					sum_d   = '0;
					seen_d  = 1'b0;
					win_d   = '0;
					if (type_q > cfg.max_type || length_d > cfg.max_length) begin
						res_valid         = 1'b1;
						res.end_of_packet = 1'b1;
						res.status        = bpd_pkg::ST_BAD_HEADER;
						phase_d           = bpd_pkg::PH_HUNT;
					end else if (length_d == '0) begin
						phase_d = bpd_pkg::PH_CHECK;
					end else begin
						phase_d = bpd_pkg::PH_PAYLOAD;
					end
				end
			end

			bpd_pkg::PH_PAYLOAD: begin
				sum_d   = sum_next;
				win_d   = win_shift;
				seen_d  = seen_next;
				count_d = count_next;
				res_valid = 1'b1;
				if (count_next == length_q && seen_next) begin
					// A sync word inside the payload means the packet was cut short.
					res.end_of_packet = 1'b1;
					res.status        = bpd_pkg::ST_TRUNCATED;
					res.computed_sum  = sum_next;
					phase_d           = bpd_pkg::PH_HUNT;
					win_d             = '0;
					fc_d              = '0;
				end else begin
					res.data_byte    = in_byte;
					res.byte_index   = count_q;
					res.computed_sum = sum_next;
					if (count_next == length_q) begin
						phase_d = bpd_pkg::PH_CHECK;
						fc_d    = '0;
					end
				end
			end

			bpd_pkg::PH_CHECK: begin
				if (fc_q == '0) begin
					cs_low_d = in_byte;
					fc_d     = 2'd1;
				end else begin
					recv_d  = {in_byte, cs_low_q};
					phase_d = bpd_pkg::PH_TRAILER;
					fc_d    = '0;
				end
			end

			bpd_pkg::PH_TRAILER: begin
				if (fc_q == '0) begin
					fc_d = 2'd1;
				end else begin
					res_valid         = 1'b1;
					res.end_of_packet = 1'b1;
					res.status        = (recv_q == sum_q) ? bpd_pkg::ST_OK
					                                      : bpd_pkg::ST_BAD_CHECKSUM;
					res.computed_sum  = sum_q;
					res.received_sum  = recv_q;
					phase_d           = bpd_pkg::PH_HUNT;
					win_d             = '0;
					fc_d              = '0;
				end
			end

			default: begin
				phase_d = bpd_pkg::PH_HUNT;
				win_d   = '0;
				fc_d    = '0;
			end
		endcase

		// Header fields are reported as they stand after this byte.
		res.packet_type   = type_d;
		res.packet_length = length_d;
	end

endmodule

`default_nettype wire

// ===== src/bpd_back.sv =====
`default_nettype none

// Output stage: takes result words from the queue into the output register.
module bpd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire bpd_pkg::result_t in_res,
	output logic                  in_pop,
	output logic                  out_valid,
	output bpd_pkg::result_t      out_res,
	input  wire logic             out_ready
);

	logic             valid_q;
	bpd_pkg::result_t res_q;

	// Load a new word whenever the register is empty or being emptied.
	assign in_pop    = in_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= in_valid;
		end
	end

	// The payload register carries no reset.
	always_ff @(posedge clk) begin
		if (in_pop) begin
			res_q <= in_res;
		end
	end

endmodule

`default_nettype wire

// ===== src/binary_packet_deframer.sv =====
// A result reaches the master side through the result queue and then the output register.
// Throughput: one byte per cycle; input stalls only when the result queue is full.
// Queue depth is FIFO_DEPTH words plus the one-word output register.
// Reset (arst_n low, asynchronous) returns to sync hunting with all counters cleared,
// empties the queue and loads max_type = 99 and max_length = 304.
`default_nettype none
`include "binary_packet_deframer_macros.svh"

module binary_packet_deframer #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Received byte stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] data_byte, [23:8] byte_index, [39:24] packet_type, [55:40] packet_length,
	// [71:56] computed_sum, [87:72] received_sum
	output logic [87:0]      m_tdata,
	output logic             m_tlast,   // end_of_packet
	output logic [1:0]       m_tuser,   // [1:0] status
	// Configuration writes.
	input  wire logic        cfg_we,
	input  wire logic [bpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	bpd_pkg::cfg_t    cfg_q;
	logic             accept;
	logic             res_valid;
	bpd_pkg::result_t res;
	logic             fifo_full;
	logic             fifo_valid;
	logic             fifo_pop;
	bpd_pkg::result_t fifo_head;
	logic             out_valid;
	bpd_pkg::result_t out_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_type   <= bpd_pkg::MAX_TYPE_RST;
			cfg_q.max_length <= bpd_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpd_pkg::CFG_MAX_TYPE:   cfg_q.max_type   <= cfg_data;
				bpd_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
			endcase
		end
	end

	// A byte is taken whenever the queue has room for its result.
	assign s_tready = !fifo_full;
	assign accept   = s_tvalid && s_tready;

	bpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_tdata),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	bpd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.pop       (fifo_pop),
		.full      (fifo_full),
		.valid     (fifo_valid),
		.head      (fifo_head)
	);

	bpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fifo_valid),
		.in_res    (fifo_head),
		.in_pop    (fifo_pop),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_ready (m_tready)
	);

	// Pack the result word onto the master side.
	assign m_tvalid = out_valid;
	assign m_tlast  = out_res.end_of_packet;
	assign m_tuser  = out_res.status;
	assign m_tdata  = {out_res.received_sum, out_res.computed_sum, out_res.packet_length,
	                   out_res.packet_type, out_res.byte_index, out_res.data_byte};

	// Nothing can reach the output when both the queue and the output register are empty.
	`BPD_ASSERT_NEXT(a_no_invented_word, clk, arst_n, !fifo_valid && !m_tvalid, !m_tvalid)
	// A payload word carries no status and no received checksum.
	`BPD_ASSERT_NOW(a_payload_clean, clk, arst_n, m_tvalid && !m_tlast, m_tuser == bpd_pkg::ST_OK && m_tdata[87:72] == 16'h0000)
	// A bad header ends the packet and carries no sums.
	`BPD_ASSERT_NOW(a_bad_header_clean, clk, arst_n, m_tvalid && m_tuser == bpd_pkg::ST_BAD_HEADER, m_tlast && m_tdata[87:56] == 32'h0000_0000)

endmodule

`default_nettype wire
